// ===== rtl/lld_pkg.sv =====
// lld_pkg: shared constants for the least-loaded work dispatcher
// command, mode, status and register codes, field widths, parameter defaults
// no dependencies
package lld_pkg;

  localparam int N_WORKERS_DEF  = 8;
  localparam int LOAD_WIDTH_DEF = 32;

  localparam int DIV_DEN_W_DEF = $clog2(N_WORKERS_DEF + 1);
  localparam int DIV_NUM_W_DEF = LOAD_WIDTH_DEF + DIV_DEN_W_DEF;

  localparam int CMD_W       = 2;
  localparam int AMOUNT_W    = 32;
  localparam int INDEX_W     = 3;
  localparam int WORKER_W    = 3;
  localparam int STATUS_W    = 2;
  localparam int OUT_LOAD_W  = 32;
  localparam int MODE_W      = 2;
  localparam int COUNT_W     = 4;
  localparam int CFG_DATA_W  = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_ASSIGN    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REBALANCE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LL = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT       = 2'd2;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

endpackage

// ===== rtl/lld_ram.sv =====
// lld_ram: generic simple dual-port ram, one write and one registered read port
// depends on lld_pkg for default sizes
module lld_ram import lld_pkg::*; #(
  parameter int WIDTH = LOAD_WIDTH_DEF,
  parameter int DEPTH = N_WORKERS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lld_div.sv =====
// lld_div: bit-serial restoring divider, one quotient bit per cycle
// depends on lld_pkg for default sizes
module lld_div import lld_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W_DEF,
  parameter int DEN_W = DIV_DEN_W_DEF,
  parameter int QUO_W = LOAD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
      cnt_r <= CNT_W'(NUM_W - 1);
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[QUO_W-1:0];

endmodule

// ===== rtl/least_loaded_work_dispatcher.sv =====
// least_loaded_work_dispatcher: top level, command sequencer around the counter ram
// depends on lld_pkg, lld_ram, lld_div
//
// One item is worked at a time; the next item is taken as soon as the current result is
// in the output register. Counters live in a ram with one read and one write port and a
// registered read. Assign in round-robin or fixed mode and release read one counter, then
// form the result; least-loaded assign first scans the n active counters (one counter
// read per cycle), with n the active worker count. A rebalance scans all active counters,
// divides the sum by n in a bit-serial divider, then reads and checks each worker in turn;
// for every worker above the upper threshold it reads and checks each counter examined,
// moves load to it if it is a receiver, then writes the donor counter back. Counter reset
// is held in per-worker valid flags, so no clearing pass runs.
module least_loaded_work_dispatcher import lld_pkg::*; #(
  parameter int N_WORKERS  = N_WORKERS_DEF,
  parameter int LOAD_WIDTH = LOAD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // command, work_amount, worker_index
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // worker, status, worker_load
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int WIDX  = $clog2(N_WORKERS);
  localparam int CW    = $clog2(N_WORKERS + 1);
  localparam int SW    = LOAD_WIDTH + CW;
  localparam int AW    = (LOAD_WIDTH > AMOUNT_W ? LOAD_WIDTH : AMOUNT_W) + 1;
  localparam int MW    = LOAD_WIDTH + 3;
  localparam int PAD_W = OUT_TDATA_W - WORKER_W - STATUS_W - OUT_LOAD_W;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_RD   = 12'b0000_0000_0010,
    S_SCAN = 12'b0000_0000_0100,
    S_WR   = 12'b0000_0000_1000,
    S_DIV  = 12'b0000_0001_0000,
    S_DRD  = 12'b0000_0010_0000,
    S_DCHK = 12'b0000_0100_0000,
    S_RRD  = 12'b0000_1000_0000,
    S_RCHK = 12'b0001_0000_0000,
    S_RMOV = 12'b0010_0000_0000,
    S_DWB  = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [MODE_W-1:0]      mode_r;
  logic [COUNT_W-1:0]     wc_r;
  logic [WIDX-1:0]        ptr_r, ptr_nxt;
  logic [N_WORKERS-1:0]   vld_r, vld_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [AMOUNT_W-1:0]   amt_r, amt_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [WIDX-1:0]       didx_r, didx_nxt;
  logic [WIDX-1:0]       wsel_r, wsel_nxt;
  logic [WIDX-1:0]       i_r, i_nxt;
  logic [WIDX-1:0]       j_r, j_nxt;
  logic [LOAD_WIDTH-1:0] cur_r, cur_nxt;
  logic [SW-1:0]         acc_r, acc_nxt;
  logic [LOAD_WIDTH-1:0] avg_r, avg_nxt;
  logic [MW-1:0]         avg6_r, avg6_nxt;
  logic [MW-1:0]         avg4_r, avg4_nxt;
  logic [LOAD_WIDTH-1:0] ldi_r, ldi_nxt;
  logic [LOAD_WIDTH-1:0] exc_r, exc_nxt;
  logic [LOAD_WIDTH-1:0] room_r, room_nxt;
  logic [LOAD_WIDTH-1:0] qj_r, qj_nxt;
  logic                  rcv_r, rcv_nxt;
  logic [WORKER_W-1:0]   res_worker_r, res_worker_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [LOAD_WIDTH-1:0] res_load_r, res_load_nxt;
  logic                  rd_vld_r;

  logic [CMD_W-1:0]      in_cmd;
  logic [AMOUNT_W-1:0]   in_amt;
  logic [INDEX_W-1:0]    in_idx;
  logic [CW-1:0]         n_cfg;
  logic [CW-1:0]         nm1;
  logic [WIDX-1:0]       rr_sel, rr_next;
  logic [CW-1:0]         rr_inc;
  logic                  idx_ok;
  logic                  accept;
  logic                  scan_last, i_last, j_last;

  logic                  ram_we, ram_re;
  logic [WIDX-1:0]       ram_waddr, ram_raddr;
  logic [LOAD_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [LOAD_WIDTH-1:0] q;
  logic [MW-1:0]         q5;
  logic [AW-1:0]         sum_w;
  logic                  sat, under;
  logic [LOAD_WIDTH-1:0] t_mv;
  logic [SW-1:0]         acc_sum;
  logic                  div_start, div_done;
  logic [LOAD_WIDTH-1:0] div_quo;

  assign in_cmd = in_tdata[1:0];
  assign in_amt = in_tdata[33:2];
  assign in_idx = in_tdata[36:34];

  always_comb begin
    if (wc_r == '0) begin
      n_cfg = CW'(1);
    end else if (int'(wc_r) > N_WORKERS) begin
      n_cfg = CW'(N_WORKERS);
    end else begin
      n_cfg = CW'(wc_r);
    end
  end

  assign rr_sel  = (CW'(ptr_r) < n_cfg) ? ptr_r : '0;
  assign rr_inc  = CW'(rr_sel) + CW'(1);
  assign rr_next = (rr_inc == n_cfg) ? '0 : rr_inc[WIDX-1:0];
  assign idx_ok  = 8'(in_idx) < 8'(n_cfg);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign nm1       = n_r - CW'(1);
  assign scan_last = CW'(didx_r) == nm1;
  assign i_last    = CW'(i_r) == nm1;
  assign j_last    = CW'(j_r) == nm1;

  // entries never written read as zero
  assign q       = rd_vld_r ? ram_rdata : '0;
  assign q5      = (MW'(q) << 2) + MW'(q);
  assign sum_w   = AW'(cur_r) + AW'(amt_r);
  assign sat     = sum_w > AW'({LOAD_WIDTH{1'b1}});
  assign under   = AW'(amt_r) > AW'(cur_r);
  assign t_mv    = (exc_r < room_r) ? exc_r : room_r;
  assign acc_sum = acc_r + SW'(q);

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    vld_nxt        = vld_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    cmd_nxt        = cmd_r;
    amt_nxt        = amt_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    didx_nxt       = didx_r;
    wsel_nxt       = wsel_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cur_nxt        = cur_r;
    acc_nxt        = acc_r;
    avg_nxt        = avg_r;
    avg6_nxt       = avg6_r;
    avg4_nxt       = avg4_r;
    ldi_nxt        = ldi_r;
    exc_nxt        = exc_r;
    room_nxt       = room_r;
    qj_nxt         = qj_r;
    rcv_nxt        = rcv_r;
    res_worker_nxt = res_worker_r;
    res_status_nxt = res_status_r;
    res_load_nxt   = res_load_r;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    div_start      = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_cmd;
          amt_nxt        = in_amt;
          n_nxt          = n_cfg;
          res_worker_nxt = '0;
          res_status_nxt = ST_OK;
          res_load_nxt   = '0;
          unique case (in_cmd)
            CMD_ASSIGN: begin
              unique case (mode_r)
                MODE_RR: begin
                  wsel_nxt  = rr_sel;
                  ptr_nxt   = rr_next;
                  ram_re    = 1'b1;
                  ram_raddr = rr_sel;
                  state_nxt = S_RD;
                end
                MODE_LL: begin
                  ram_re    = 1'b1;
                  cnt_nxt   = CW'(1);
                  didx_nxt  = '0;
                  state_nxt = S_SCAN;
                end
                default: begin
                  wsel_nxt  = '0;
                  ram_re    = 1'b1;
                  state_nxt = S_RD;
                end
              endcase
            end
            CMD_RELEASE: begin
              if (idx_ok) begin
                wsel_nxt  = WIDX'(in_idx);
                ram_re    = 1'b1;
                ram_raddr = WIDX'(in_idx);
                state_nxt = S_RD;
              end else begin
                res_worker_nxt = in_idx;
                res_status_nxt = ST_BAD_INDEX;
                state_nxt      = S_OUT;
              end
            end
            CMD_REBALANCE: begin
              ram_re    = 1'b1;
              cnt_nxt   = CW'(1);
              didx_nxt  = '0;
              acc_nxt   = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              res_status_nxt = ST_BAD_INDEX;
              state_nxt      = S_OUT;
            end
          endcase
        end
      end

      S_RD: begin
        cur_nxt   = q;
        state_nxt = S_WR;
      end

      S_SCAN: begin
        if (cnt_r < n_r) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r[WIDX-1:0];
          cnt_nxt   = cnt_r + CW'(1);
        end
        didx_nxt = cnt_r[WIDX-1:0];
        if (cmd_r == CMD_ASSIGN) begin
          // strict compare keeps the lowest index on ties
          if (didx_r == '0 || q < cur_r) begin
            cur_nxt  = q;
            wsel_nxt = didx_r;
          end
        end else begin
          acc_nxt = acc_sum;
        end
        if (scan_last) begin
          if (cmd_r == CMD_ASSIGN) begin
            state_nxt = S_WR;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end

      S_WR: begin
        res_worker_nxt = WORKER_W'(wsel_r);
        res_load_nxt   = cur_r;
        if (cmd_r == CMD_ASSIGN) begin
          if (mode_r == MODE_RR || mode_r == MODE_LL) begin
            ram_we    = 1'b1;
            ram_waddr = wsel_r;
            ram_wdata = sat ? '1 : sum_w[LOAD_WIDTH-1:0];
            res_load_nxt = ram_wdata;
            if (sat) begin
              res_status_nxt = ST_SAT;
            end
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = wsel_r;
          ram_wdata = under ? '0 : cur_r - LOAD_WIDTH'(amt_r);
          res_load_nxt = ram_wdata;
          if (under) begin
            res_status_nxt = ST_SAT;
          end
        end
        state_nxt = S_OUT;
      end

      S_DIV: begin
        if (div_done) begin
          avg_nxt   = div_quo;
          avg6_nxt  = (MW'(div_quo) << 2) + (MW'(div_quo) << 1);
          avg4_nxt  = MW'(div_quo) << 2;
          i_nxt     = '0;
          state_nxt = S_DRD;
        end
      end

      S_DRD: begin
        ram_re    = 1'b1;
        ram_raddr = i_r;
        state_nxt = S_DCHK;
      end

      S_DCHK: begin
        if (q5 > avg6_r) begin
          ldi_nxt   = q;
          exc_nxt   = q - avg_r;
          j_nxt     = '0;
          state_nxt = S_RRD;
        end else if (i_last) begin
          res_load_nxt = avg_r;
          state_nxt    = S_OUT;
        end else begin
          i_nxt     = i_r + WIDX'(1);
          state_nxt = S_DRD;
        end
      end

      S_RRD: begin
        ram_re    = 1'b1;
        ram_raddr = j_r;
        state_nxt = S_RCHK;
      end

      S_RCHK: begin
        rcv_nxt   = avg4_r > q5;
        room_nxt  = avg_r - q;
        qj_nxt    = q;
        state_nxt = S_RMOV;
      end

      S_RMOV: begin
        if (rcv_r) begin
          ram_we    = 1'b1;
          ram_waddr = j_r;
          ram_wdata = qj_r + t_mv;
          ldi_nxt   = ldi_r - t_mv;
          exc_nxt   = exc_r - t_mv;
        end
        if ((rcv_r && exc_r == t_mv) || j_last) begin
          state_nxt = S_DWB;
        end else begin
          j_nxt     = j_r + WIDX'(1);
          state_nxt = S_RRD;
        end
      end

      S_DWB: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = ldi_r;
        if (i_last) begin
          res_load_nxt = avg_r;
          state_nxt    = S_OUT;
        end else begin
          i_nxt     = i_r + WIDX'(1);
          state_nxt = S_DRD;
        end
      end

      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{PAD_W{1'b0}}, OUT_LOAD_W'(res_load_r), res_status_r,
                            res_worker_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= '0;
      wc_r         <= COUNT_W'(8);
      ptr_r        <= '0;
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      vld_r        <= vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_MODE:  mode_r <= cfg_wdata[MODE_W-1:0];
          REG_COUNT: wc_r   <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r  <= out_tdata_nxt;
    cmd_r        <= cmd_nxt;
    amt_r        <= amt_nxt;
    n_r          <= n_nxt;
    cnt_r        <= cnt_nxt;
    didx_r       <= didx_nxt;
    wsel_r       <= wsel_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    cur_r        <= cur_nxt;
    acc_r        <= acc_nxt;
    avg_r        <= avg_nxt;
    avg6_r       <= avg6_nxt;
    avg4_r       <= avg4_nxt;
    ldi_r        <= ldi_nxt;
    exc_r        <= exc_nxt;
    room_r       <= room_nxt;
    qj_r         <= qj_nxt;
    rcv_r        <= rcv_nxt;
    res_worker_r <= res_worker_nxt;
    res_status_r <= res_status_nxt;
    res_load_r   <= res_load_nxt;
    if (ram_re) begin
      rd_vld_r <= vld_r[ram_raddr];
    end
  end

  lld_ram #(
    .WIDTH (LOAD_WIDTH),
    .DEPTH (N_WORKERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lld_div #(
    .NUM_W (SW),
    .DEN_W (CW),
    .QUO_W (LOAD_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_sum),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_donor_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWB) |-> (ldi_r >= avg_r))
    else $error("donor counter dropped below the average");

  a_receiver_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RMOV && rcv_r) |-> (ram_wdata <= avg_r))
    else $error("receiver counter raised above the average");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the average step");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction taken while an item is in work");

endmodule
